// ----- rtl/vpst_pkg.sv -----
package vpst_pkg;

   localparam int MAP_SIZE     = 256;
   localparam int MAP_MID      = MAP_SIZE / 2;
   localparam int BACK_RADIUS  = 8;
   localparam int CORNER_COUNT = 5;
   localparam int BACK_ANGLE   = 150;
   localparam int DIST_CAP     = 125;
   localparam int FRAC_BITS    = 16;
   localparam int DIV_BITS     = 8 + FRAC_BITS;

   localparam logic [1:0] CSR_HALF_FOV      = 2'd0;
   localparam logic [1:0] CSR_VIEW_DISTANCE = 2'd1;
   localparam logic [1:0] CSR_VIEWER_ROTATE = 2'd2;

   localparam logic CMD_REBUILD = 1'b0;
   localparam logic CMD_TEST    = 1'b1;

   typedef struct packed {
      logic accept;
      logic place;
      logic walk_init;
      logic edge_load;
      logic div_step;
      logic scan_step;
      logic edge_next;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic place_last;
      logic flat;
      logic div_last;
      logic scan_last;
      logic walk_done;
      logic walk_right;
      logic rsp_free;
   } sts_type;

   // Q1.14 sine magnitude, whole degrees 0..90
   function automatic logic [14:0] sine_q14(input logic [6:0] d);
      logic [14:0] v;
      case (d)
         7'd0: v = 15'd0;       7'd1: v = 15'd286;     7'd2: v = 15'd572;
         7'd3: v = 15'd857;     7'd4: v = 15'd1143;    7'd5: v = 15'd1428;
         7'd6: v = 15'd1713;    7'd7: v = 15'd1997;    7'd8: v = 15'd2280;
         7'd9: v = 15'd2563;    7'd10: v = 15'd2845;   7'd11: v = 15'd3126;
         7'd12: v = 15'd3406;   7'd13: v = 15'd3686;   7'd14: v = 15'd3964;
         7'd15: v = 15'd4240;   7'd16: v = 15'd4516;   7'd17: v = 15'd4790;
         7'd18: v = 15'd5063;   7'd19: v = 15'd5334;   7'd20: v = 15'd5604;
         7'd21: v = 15'd5872;   7'd22: v = 15'd6138;   7'd23: v = 15'd6402;
         7'd24: v = 15'd6664;   7'd25: v = 15'd6924;   7'd26: v = 15'd7182;
         7'd27: v = 15'd7438;   7'd28: v = 15'd7692;   7'd29: v = 15'd7943;
         7'd30: v = 15'd8192;   7'd31: v = 15'd8438;   7'd32: v = 15'd8682;
         7'd33: v = 15'd8923;   7'd34: v = 15'd9162;   7'd35: v = 15'd9397;
         7'd36: v = 15'd9630;   7'd37: v = 15'd9860;   7'd38: v = 15'd10087;
         7'd39: v = 15'd10311;  7'd40: v = 15'd10531;  7'd41: v = 15'd10749;
         7'd42: v = 15'd10963;  7'd43: v = 15'd11174;  7'd44: v = 15'd11381;
         7'd45: v = 15'd11585;  7'd46: v = 15'd11786;  7'd47: v = 15'd11982;
         7'd48: v = 15'd12176;  7'd49: v = 15'd12365;  7'd50: v = 15'd12551;
         7'd51: v = 15'd12733;  7'd52: v = 15'd12911;  7'd53: v = 15'd13085;
         7'd54: v = 15'd13255;  7'd55: v = 15'd13421;  7'd56: v = 15'd13583;
         7'd57: v = 15'd13741;  7'd58: v = 15'd13894;  7'd59: v = 15'd14044;
         7'd60: v = 15'd14189;  7'd61: v = 15'd14330;  7'd62: v = 15'd14466;
         7'd63: v = 15'd14598;  7'd64: v = 15'd14726;  7'd65: v = 15'd14849;
         7'd66: v = 15'd14968;  7'd67: v = 15'd15082;  7'd68: v = 15'd15191;
         7'd69: v = 15'd15296;  7'd70: v = 15'd15396;  7'd71: v = 15'd15491;
         7'd72: v = 15'd15582;  7'd73: v = 15'd15668;  7'd74: v = 15'd15749;
         7'd75: v = 15'd15826;  7'd76: v = 15'd15897;  7'd77: v = 15'd15964;
         7'd78: v = 15'd16026;  7'd79: v = 15'd16083;  7'd80: v = 15'd16135;
         7'd81: v = 15'd16182;  7'd82: v = 15'd16225;  7'd83: v = 15'd16262;
         7'd84: v = 15'd16294;  7'd85: v = 15'd16322;  7'd86: v = 15'd16344;
         7'd87: v = 15'd16362;  7'd88: v = 15'd16374;  7'd89: v = 15'd16382;
         7'd90: v = 15'd16384;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

   // sine magnitude for an angle 0..359
   function automatic logic [14:0] sin_mag(input logic [8:0] a);
      logic [8:0] d;
      if (a <= 9'd90)       d = a;
      else if (a <= 9'd180) d = 9'd180 - a;
      else if (a <= 9'd270) d = a - 9'd180;
      else                  d = 9'd360 - a;
      return sine_q14(d[6:0]);
   endfunction

endpackage

// ----- rtl/vpst_ctrl.sv -----
module vpst_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_tuser,
   input  vpst_pkg::sts_type sts,
   output vpst_pkg::cmd_type cmd
);
   import vpst_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PLACE  = 8'b0000_0010,
      ST_WINIT  = 8'b0000_0100,
      ST_EDGE   = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_SCAN   = 8'b0010_0000,
      ST_NEXT   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = (req_tuser == CMD_REBUILD) ? ST_PLACE : ST_FINISH;
            end
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
            if (sts.place_last) state_in = ST_WINIT;
         end
         ST_WINIT: begin
            cmd.walk_init = 1'b1;
            state_in      = ST_EDGE;
         end
         ST_EDGE: begin
            cmd.edge_load = 1'b1;
            state_in      = sts.flat ? ST_NEXT : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) state_in = ST_NEXT;
         end
         ST_NEXT: begin
            cmd.edge_next = 1'b1;
            state_in      = (sts.walk_done && sts.walk_right) ? ST_FINISH : ST_EDGE;
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/vpst_datapath.sv -----
module vpst_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [8:0]        csr_wdata,
   input  logic [31:0]       req_tdata,
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,
   output logic              rsp_tuser,
   input  vpst_pkg::cmd_type cmd,
   output vpst_pkg::sts_type sts
);
   import vpst_pkg::*;

   // configuration
   logic [6:0] fov_ff, dist_ff;
   logic [8:0] rot_ff;
   logic [6:0] dist_wr;

   assign dist_wr = (csr_wdata[6:0] > 7'(DIST_CAP)) ? 7'(DIST_CAP) : csr_wdata[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff  <= 7'd45;
         dist_ff <= 7'd45;
         rot_ff  <= 9'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HALF_FOV:      fov_ff  <= csr_wdata[6:0];
            CSR_VIEW_DISTANCE: dist_ff <= dist_wr;
            CSR_VIEWER_ROTATE: rot_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // corners
   logic [7:0] cx_ff [CORNER_COUNT];
   logic [7:0] cz_ff [CORNER_COUNT];
   logic [2:0] pidx_ff, near_ff, far_ff;
   logic       built_ff, kind_ff;
   logic signed [15:0] px_ff, pz_ff;

   logic signed [9:0] offset;
   logic [6:0]        radius;
   logic [10:0]       sum;
   logic [8:0]        ang_a, ang_c;
   logic [14:0]       mag_a, mag_c;
   logic [21:0]       prod_a, prod_c;
   logic [7:0]        off_a, off_c, new_x, new_z;

   always_comb begin
      case (pidx_ff)
         3'd0:    begin offset = 10'(BACK_ANGLE);      radius = 7'(BACK_RADIUS); end
         3'd1:    begin offset = -10'(BACK_ANGLE);     radius = 7'(BACK_RADIUS); end
         3'd2:    begin offset = -$signed({3'b0, fov_ff}); radius = dist_ff; end
         3'd3:    begin offset = 10'sd0;               radius = dist_ff; end
         default: begin offset = $signed({3'b0, fov_ff}); radius = dist_ff; end
      endcase
      sum = 11'({2'b0, rot_ff} + 11'd360 + 11'(offset));
      if (sum >= 11'd720)      ang_a = 9'(sum - 11'd720);
      else if (sum >= 11'd360) ang_a = 9'(sum - 11'd360);
      else                     ang_a = sum[8:0];
      ang_c  = (ang_a >= 9'd270) ? ang_a - 9'd270 : ang_a + 9'd90;
      mag_a  = sin_mag(ang_a);
      mag_c  = sin_mag(ang_c);
      prod_a = radius * mag_a;
      prod_c = radius * mag_c;
      off_a  = prod_a[21:14];
      off_c  = prod_c[21:14];
      new_x  = (ang_a > 9'd180) ? 8'(MAP_MID) - off_a : 8'(MAP_MID) + off_a;
      new_z  = (ang_c > 9'd180) ? 8'(MAP_MID) - off_c : 8'(MAP_MID) + off_c;
   end

   assign sts.place_last = (pidx_ff == 3'(CORNER_COUNT - 1));

   // edge walk
   logic [2:0] cur_ff, cnt_ff, nxt, target, cnt_inc;
   logic       right_ff;
   logic [7:0] ax, az, bx, bz, sx, sz, dz;
   logic signed [8:0] dx;
   logic [7:0] abs_dx;

   assign nxt     = (cur_ff == 3'(CORNER_COUNT - 1)) ? 3'd0 : cur_ff + 3'd1;
   assign target  = right_ff ? near_ff : far_ff;
   assign cnt_inc = cnt_ff + 3'd1;
   assign sts.walk_done  = (nxt == target) || (cnt_inc == 3'(CORNER_COUNT));
   assign sts.walk_right = right_ff;

   always_comb begin
      ax = cx_ff[cur_ff];
      az = cz_ff[cur_ff];
      bx = cx_ff[nxt];
      bz = cz_ff[nxt];
      if (az > bz) begin
         sx = bx; sz = bz; dz = az - bz;
         dx = $signed({1'b0, ax}) - $signed({1'b0, bx});
      end else begin
         sx = ax; sz = az; dz = bz - az;
         dx = $signed({1'b0, bx}) - $signed({1'b0, ax});
      end
      abs_dx = dx[8] ? 8'(-dx) : dx[7:0];
   end

   assign sts.flat = (az == bz);

   // slope divider and row accumulator
   logic [DIV_BITS-1:0] quo_ff;
   logic [7:0]          rem_ff, dz_ff, row_ff, rows_ff;
   logic [4:0]          dcnt_ff;
   logic                neg_ff;
   logic [8:0]          trial;
   logic signed [25:0]  acc_ff, slope;

   assign trial        = {rem_ff, quo_ff[DIV_BITS-1]};
   assign sts.div_last = (dcnt_ff == 5'(DIV_BITS - 1));
   assign slope        = neg_ff ? -$signed({2'b0, quo_ff}) : $signed({2'b0, quo_ff});
   assign sts.scan_last = (rows_ff == 8'd0);

   // span tables
   logic [7:0] left_mem  [MAP_SIZE];
   logic [7:0] right_mem [MAP_SIZE];
   logic       wr_en;
   logic [7:0] wr_row, wr_val, rdl_ff, rdr_ff;

   always_comb begin
      wr_en  = 1'b0;
      wr_row = row_ff;
      wr_val = acc_ff[FRAC_BITS+7:FRAC_BITS];
      if (cmd.edge_load && sts.flat) begin
         wr_en  = 1'b1;
         wr_row = az;
         wr_val = ((ax <= bx) != right_ff) ? ax : bx;
      end else if (cmd.scan_step) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !right_ff) left_mem[wr_row]  <= wr_val;
      if (wr_en && right_ff)  right_mem[wr_row] <= wr_val;
      if (cmd.accept) begin
         rdl_ff <= left_mem[req_tdata[23:16]];
         rdr_ff <= right_mem[req_tdata[23:16]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORNER_COUNT; i++) begin
            cx_ff[i] <= 8'd0;
            cz_ff[i] <= 8'd0;
         end
         near_ff  <= 3'd0;
         far_ff   <= 3'd0;
         built_ff <= 1'b0;
         pidx_ff  <= 3'd0;
         cur_ff   <= 3'd0;
         cnt_ff   <= 3'd0;
         right_ff <= 1'b0;
         dcnt_ff  <= 5'd0;
      end else begin
         if (cmd.accept) pidx_ff <= 3'd0;
         if (cmd.place) begin
            cx_ff[pidx_ff] <= new_x;
            cz_ff[pidx_ff] <= new_z;
            pidx_ff        <= pidx_ff + 3'd1;
            if (pidx_ff == 3'd0) begin
               near_ff <= 3'd0;
               far_ff  <= 3'd0;
            end else begin
               if (new_z < cz_ff[near_ff]) near_ff <= pidx_ff;
               if (new_z > cz_ff[far_ff])  far_ff  <= pidx_ff;
            end
         end
         if (cmd.walk_init) begin
            cur_ff   <= near_ff;
            cnt_ff   <= 3'd0;
            right_ff <= 1'b0;
         end
         if (cmd.edge_load) dcnt_ff <= 5'd0;
         if (cmd.div_step)  dcnt_ff <= dcnt_ff + 5'd1;
         if (cmd.edge_next) begin
            if (sts.walk_done && !right_ff) begin
               right_ff <= 1'b1;
               cur_ff   <= far_ff;
               cnt_ff   <= 3'd0;
            end else begin
               cur_ff <= nxt;
               cnt_ff <= cnt_inc;
            end
         end
         if (cmd.load_rsp && kind_ff == CMD_REBUILD) built_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_tuser;
         px_ff   <= $signed(req_tdata[15:0]);
         pz_ff   <= $signed(req_tdata[31:16]);
      end
      if (cmd.edge_load) begin
         row_ff  <= sz;
         rows_ff <= dz;
         dz_ff   <= dz;
         neg_ff  <= dx[8];
         quo_ff  <= {abs_dx, FRAC_BITS'(0)};
         rem_ff  <= 8'd0;
         acc_ff  <= $signed({2'b0, sx, FRAC_BITS'(0)});
      end
      if (cmd.div_step) begin
         if (trial >= {1'b0, dz_ff}) begin
            rem_ff <= 8'(trial - {1'b0, dz_ff});
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= trial[7:0];
            quo_ff <= {quo_ff[DIV_BITS-2:0], 1'b0};
         end
      end
      if (cmd.scan_step) begin
         acc_ff  <= acc_ff + slope;
         row_ff  <= row_ff + 8'd1;
         rows_ff <= rows_ff - 8'd1;
      end
   end

   // point test
   logic [7:0] lspan, rspan;
   logic       row_ok, col_ok, hit;

   assign lspan  = built_ff ? rdl_ff : 8'd0;
   assign rspan  = built_ff ? rdr_ff : 8'd0;
   assign row_ok = (pz_ff[15:8] == 8'd0) && (pz_ff[7:0] >= cz_ff[near_ff])
                   && (pz_ff[7:0] <= cz_ff[far_ff]);
   assign col_ok = (px_ff >= $signed({8'b0, lspan})) && (px_ff <= $signed({8'b0, rspan}));
   assign hit    = (kind_ff == CMD_TEST) && row_ok && col_ok;

   // result register
   logic rsp_valid_ff;

   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.load_rsp) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_tdata <= {7'b0, hit};
         rsp_tuser <= (kind_ff == CMD_REBUILD);
      end
   end

endmodule

// ----- rtl/view_pentagon_span_test.sv -----
// View pentagon span test. A rebuild item (tuser 0) places five corners around the
// map middle from the current half_fov, view_distance and viewer_rotate registers,
// then scan-converts the pentagon edges into left and right span tables (one
// 256-row table each); it answers inside 0 with the rebuilt flag set. A test
// item (tuser 1) answers whether its point lies between the lowest and highest
// corner rows and within that row's span. Items are handled one at a time.
// A test reads the span tables on acceptance, then compares into the result
// register. A rebuild runs the accept, corner placement (one corner a cycle),
// walk setup, then per edge an edge load, for a sloped edge the bit-serial
// slope divider (24-bit quotient) and the span scan (one span row written per
// cycle), then a step to the next edge; last it loads the result. The two
// walks stop at their end corners or after every edge. A new item is taken
// while the previous result waits, but its own waits until that one is taken.
// Registers may be written only when the block is idle; they take effect at
// the next rebuild.
module view_pentagon_span_test (
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata,
   // item input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] point_x, [31:16] point_z
   input  logic        req_tuser,   // [0] command
   // result output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] inside_res, [7:1] zero
   output logic        rsp_tuser    // [0] rebuilt
);
   import vpst_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: item accept, placement, edge walks, result hand-off
   vpst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   // corners, slope divider, span tables, point compare, result register
   vpst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- sim/testbench.sv -----
module testbench;
   import vpst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SINE_Q14 [0:90] = '{
      0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
      2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
      5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
      8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
      10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
      12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
      14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
      15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
      16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
      16384};
   localparam int  ROWS        = 256;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam int  DRAIN_WAIT  = 800;

   typedef struct packed {
      logic hit;
      logic rebuilt;
   } answer_type;

   typedef struct {
      logic        cmd;
      int          px;
      int          pz;
      logic        check_fixed;  // result typed in the table row
      answer_type  fixed;
   } probe_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [8:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;

   // model state
   int          fov_deg, view_dist, heading;
   int          cx [CORNER_COUNT];
   int          cz [CORNER_COUNT];
   int          low_corner, high_corner;
   logic [7:0]  left_tab [ROWS];
   logic [7:0]  right_tab [ROWS];

   answer_type  answers_due [$];
   int          errors;
   int          cycles = 0;
   int          n_items, n_rebuilds, n_inside;
   int          send_idle_pct, recv_idle_pct;
   bit          hold_recv;

   always #10 clock = ~clock;

   view_pentagon_span_test DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // ---------------- model of the block ----------------
   function automatic int sine_of(int a);
      if (a <= 90) return SINE_Q14[a];
      if (a <= 180) return SINE_Q14[180 - a];
      if (a <= 270) return -SINE_Q14[a - 180];
      return -SINE_Q14[360 - a];
   endfunction

   // r*s >> 14 rounded toward zero
   function automatic int offset_of(int r, int s);
      int p;
      p = r * s;
      return (p >= 0) ? (p >>> 14) : -((-p) >>> 14);
   endfunction

   task automatic set_corner(int idx, int delta, int radius);
      int a, c;
      a = (heading + delta + 720) % 360;
      c = (a + 90) % 360;
      cx[idx] = MAP_MID + offset_of(radius, sine_of(a));
      cz[idx] = MAP_MID + offset_of(radius, sine_of(c));
   endtask

   task automatic span_write(bit left, int row, longint col);
      if (row >= 0 && row < ROWS) begin
         if (left) left_tab[row] = col[7:0];
         else right_tab[row] = col[7:0];
      end
   endtask

   task automatic trace_edge(int sx, int sz, int ex, int ez, bit left);
      int     t, dz;
      longint slope, v, w;
      if (sz == ez) begin
         // flat edge: left keeps the smaller column, right the larger
         if (left) span_write(1'b1, sz, (sx <= ex) ? sx : ex);
         else span_write(1'b0, sz, (sx >= ex) ? sx : ex);
         return;
      end
      if (sz > ez) begin
         t = sz; sz = ez; ez = t;
         t = sx; sx = ex; ex = t;
      end
      dz = ez - sz;
      slope = (longint'(ex - sx) * 65536) / dz;
      for (int j = 0; j <= dz; j++) begin
         v = longint'(sx) * 65536 + slope * j;
         w = (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
         span_write(left, sz + j, w);
      end
   endtask

   task automatic trace_chain(int from, int to, bit left);
      int cur, nxt, count;
      cur = from;
      count = 0;
      do begin
         nxt = (cur + 1) % CORNER_COUNT;
         trace_edge(cx[cur], cz[cur], cx[nxt], cz[nxt], left);
         cur = nxt;
         count++;
      end while (cur != to && count < CORNER_COUNT);
   endtask

   task automatic rebuild_pentagon();
      set_corner(0, BACK_ANGLE, BACK_RADIUS);
      set_corner(1, -BACK_ANGLE, BACK_RADIUS);
      set_corner(2, -fov_deg, view_dist);
      set_corner(3, 0, view_dist);
      set_corner(4, fov_deg, view_dist);
      low_corner = 0;
      high_corner = 0;
      for (int i = 1; i < CORNER_COUNT; i++) begin
         if (cz[i] < cz[low_corner]) low_corner = i;
         if (cz[i] > cz[high_corner]) high_corner = i;
      end
      trace_chain(low_corner, high_corner, 1'b1);
      trace_chain(high_corner, low_corner, 1'b0);
   endtask

   function automatic logic point_inside(int x, int z);
      if (z > cz[high_corner] || z < cz[low_corner]) return 1'b0;
      if (z >= MAP_SIZE || z < 0 || z >= ROWS) return 1'b0;
      if (x > int'(right_tab[z]) || x < int'(left_tab[z])) return 1'b0;
      return 1'b1;
   endfunction

   task automatic answer_for(input logic cmd, input int x, input int z,
                             output answer_type a);
      if (cmd == CMD_REBUILD) begin
         rebuild_pentagon();
         a.hit = 1'b0;
         a.rebuilt = 1'b1;
      end else begin
         a.hit = point_inside(x, z);
         a.rebuilt = 1'b0;
      end
   endtask

   task automatic report(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d (item %0d)", what, got, want, n_items);
      errors++;
   endtask

   // ---------------- drivers ----------------
   task automatic csr_write(logic [1:0] idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[8:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HALF_FOV) fov_deg = value & 'h7F;
      else if (idx == CSR_VIEW_DISTANCE)
         view_dist = ((value & 'h7F) > DIST_CAP) ? DIST_CAP : (value & 'h7F);
      else if (idx == CSR_VIEWER_ROTATE) heading = value & 'h1FF;
   endtask

   // called at a falling edge; returns at a falling edge after acceptance,
   // with tvalid still up until the next item or drain takes it down
   task automatic send_item(probe_type p);
      answer_type a;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= p.cmd;
      req_tdata <= {p.pz[15:0], p.px[15:0]};
      do @(posedge clock); while (!req_tready);
      answer_for(p.cmd, p.px, p.pz, a);
      if (p.check_fixed && a != p.fixed) begin
         // table entry disagrees with the model itself
         report("table entry", p.fixed, a);
      end
      answers_due.push_back(a);
      n_items++;
      if (p.cmd == CMD_REBUILD) n_rebuilds++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic int pick_coord();
      case ($urandom_range(9))
         0: return $signed($urandom_range(65535) - 32768);
         1: return $urandom_range(1) ? 32767 : -32768;
         2: return $urandom_range(300) - 20;
         default: return $urandom_range(120) + 68;
      endcase
   endfunction

   task automatic random_items(int count);
      probe_type p;
      for (int i = 0; i < count; i++) begin
         p.cmd = ($urandom_range(39) == 0) ? CMD_REBUILD : CMD_TEST;
         p.px = pick_coord();
         p.pz = pick_coord();
         p.check_fixed = 1'b0;
         p.fixed = '0;
         send_item(p);
      end
   endtask

   task automatic random_config();
      case ($urandom_range(3))
         0: csr_write(CSR_HALF_FOV, $urandom_range(127));
         1: csr_write(CSR_HALF_FOV, $urandom_range(1) ? 0 : 90);
         default: csr_write(CSR_HALF_FOV, $urandom_range(90));
      endcase
      csr_write(CSR_VIEW_DISTANCE, $urandom_range(3) == 0 ? $urandom_range(511)
                                                            : $urandom_range(125));
      csr_write(CSR_VIEWER_ROTATE, $urandom_range(511));
   endtask

   // ---------------- result monitor ----------------
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (answers_due.size() == 0) begin
            report("result with none expected", rsp_tdata[0], -1);
         end else begin
            want = answers_due.pop_front();
            if (rsp_tdata[0] !== want.hit) report("inside", rsp_tdata[0], want.hit);
            if (rsp_tuser !== want.rebuilt) report("rebuilt", rsp_tuser, want.rebuilt);
            if (rsp_tdata[7:1] !== 7'd0) report("tdata pad", rsp_tdata[7:1], 0);
            if (want.hit) n_inside++;
         end
      end
   end

   // receiver ready, random per cycle unless held off
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_recv) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // timeout watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      probe_type directed [$];
      probe_type p;
      errors = 0;
      n_items = 0;
      n_rebuilds = 0;
      n_inside = 0;
      hold_recv = 1'b0;
      send_idle_pct = 22;
      recv_idle_pct = 70;
      fov_deg = 45;
      view_dist = 45;
      heading = 0;
      foreach (cx[i]) begin
         cx[i] = 0;
         cz[i] = 0;
      end
      low_corner = 0;
      high_corner = 0;
      foreach (left_tab[i]) begin
         left_tab[i] = '0;
         right_tab[i] = '0;
      end

      // directed rows: {cmd, x, z, fixed?, {inside, rebuilt}}
      // test before any rebuild: all corners at origin, only (0,0) inside
      directed.push_back('{CMD_TEST, 0, 0, 1'b1, 2'b10});
      directed.push_back('{CMD_TEST, 1, 0, 1'b1, 2'b00});
      directed.push_back('{CMD_TEST, 0, 1, 1'b1, 2'b00});
      directed.push_back('{CMD_TEST, -32768, -32768, 1'b1, 2'b00});
      directed.push_back('{CMD_TEST, 32767, 32767, 1'b1, 2'b00});
      directed.push_back('{CMD_REBUILD, 0, 0, 1'b1, 2'b01});
      directed.push_back('{CMD_TEST, 128, 128, 1'b1, 2'b10});   // map middle
      directed.push_back('{CMD_TEST, 128, 160, 1'b0, 2'b00});
      directed.push_back('{CMD_TEST, 100, 150, 1'b0, 2'b00});
      directed.push_back('{CMD_TEST, 128, -1, 1'b1, 2'b00});    // negative row
      directed.push_back('{CMD_TEST, -1, 128, 1'b1, 2'b00});
      directed.push_back('{CMD_TEST, 255, 173, 1'b0, 2'b00});
      directed.push_back('{CMD_TEST, 128, 120, 1'b0, 2'b00});
      directed.push_back('{CMD_TEST, 32767, -32768, 1'b1, 2'b00});

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings first
      foreach (directed[i]) send_item(directed[i]);
      drain();

      // extremes of the registers: flat edges and out-of-range angles
      csr_write(CSR_HALF_FOV, 0);
      csr_write(CSR_VIEW_DISTANCE, 127);     // saturates to 125
      csr_write(CSR_VIEWER_ROTATE, 0);
      for (int k = 0; k < 4; k++) begin
         p = '{CMD_REBUILD, 0, 0, 1'b0, 2'b01};
         send_item(p);
         random_items(8);
         drain();
         case (k)
            0: begin csr_write(CSR_HALF_FOV, 90); csr_write(CSR_VIEWER_ROTATE, 90); end
            1: begin csr_write(CSR_HALF_FOV, 127); csr_write(CSR_VIEWER_ROTATE, 511); end
            2: begin csr_write(CSR_VIEW_DISTANCE, 0); csr_write(CSR_VIEWER_ROTATE, 359); end
            default: ;
         endcase
      end

      // random phases with three idling patterns
      for (int ph = 0; ph < 36; ph++) begin
         if (ph == 12) begin send_idle_pct = 70; recv_idle_pct = 22; end
         if (ph == 24) begin send_idle_pct = 0; recv_idle_pct = 0; end
         random_config();
         p = '{CMD_REBUILD, 0, 0, 1'b0, 2'b01};
         send_item(p);
         if (ph == 5 || ph == 30) begin
            // long receiver hold-off while the sender keeps offering items
            hold_recv = 1'b1;
            fork
               begin
                  repeat (300) @(negedge clock);
                  hold_recv = 1'b0;
               end
               random_items(12);
            join
         end
         random_items(44);
         drain();  // sender pauses until every result is in
      end

      drain();
      $display("covered %0d items, %0d rebuilds, %0d points inside, over 41 settings",
               n_items, n_rebuilds, n_inside);
      $display("register extremes, flat edges, saturated distance, and stall phases run");
      if (errors == 0 && answers_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
rtl/vpst_pkg.sv
rtl/vpst_ctrl.sv
rtl/vpst_datapath.sv
rtl/view_pentagon_span_test.sv
sim/testbench.sv
